[design/dwtq7_pkg.sv]
// Shared types and constants for the Q7 single-level wavelet block.
// Used by dwtq7_mac and dwt_q7_single_level; depends on nothing else.
package dwtq7_pkg;

    // Input operation codes (carried in tuser)
    localparam logic OP_TAP    = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_EDGE_MODE   = 1'b0;
    localparam logic REG_FILTER_TAPS = 1'b1;

    // Edge extension modes
    localparam logic [2:0] EDGE_ZERO  = 3'd0;
    localparam logic [2:0] EDGE_CONST = 3'd1;
    localparam logic [2:0] EDGE_SYM   = 3'd2;
    localparam logic [2:0] EDGE_REFL  = 3'd3;
    localparam logic [2:0] EDGE_ASYM  = 3'd4;
    localparam logic [2:0] EDGE_AREFL = 3'd5;

    localparam int DW      = 8;   // sample and tap width
    localparam int XW      = 16;  // extended edge value width
    localparam int ACC_W   = 32;  // accumulator width
    localparam int Q_SHIFT = 7;   // Q7 scaling

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_EDGE_RD1,
        ST_EDGE_RD2,
        ST_EDGE_WR,
        ST_CALC,
        ST_DRAIN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic valid;
        logic first;
    } t_mac_ctl;

endpackage

[design/dwtq7_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dwtq7_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/dwtq7_mac.sv]
// Shared multiply-accumulate pair: one low-pass and one high-pass product a cycle.
// Depends on dwtq7_pkg.
module dwtq7_mac import dwtq7_pkg::*; (
    input  logic                    i_clk,
    input  t_mac_ctl                i_ctl,
    input  logic signed [XW-1:0]    i_value,
    input  logic signed [DW-1:0]    i_low_tap,
    input  logic signed [DW-1:0]    i_high_tap,
    output logic signed [ACC_W-1:0] o_acc_lo,
    output logic signed [ACC_W-1:0] o_acc_hi
);

    logic signed [XW+DW-1:0]  prod_lo;
    logic signed [XW+DW-1:0]  prod_hi;
    logic signed [ACC_W-1:0]  ext_lo;
    logic signed [ACC_W-1:0]  ext_hi;
    logic signed [ACC_W-1:0]  r_acc_lo;
    logic signed [ACC_W-1:0]  r_acc_hi;

    assign prod_lo = i_value * i_low_tap;
    assign prod_hi = i_value * i_high_tap;
    assign ext_lo  = ACC_W'(prod_lo);
    assign ext_hi  = ACC_W'(prod_hi);

    // Restart the sums on the first term of each offset
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_acc_lo <= i_ctl.first ? ext_lo : r_acc_lo + ext_lo;
            r_acc_hi <= i_ctl.first ? ext_hi : r_acc_hi + ext_hi;
        end
    end

    assign o_acc_lo = r_acc_lo;
    assign o_acc_hi = r_acc_hi;

endmodule

[design/dwt_q7_single_level.sv]
// Top level of the single-level Q7 wavelet decomposition block.
// Depends on dwtq7_pkg, dwtq7_ram and dwtq7_mac.
//
// Tap-write transactions (tuser = 0) load one low/high tap pair.
// Sample transactions (tuser = 1) append to a 64-deep signal RAM; the
// sample marked with tlast starts the transform over the N held samples with L taps
// (filter_taps, clamped and made even). The block first latches the tap count and
// mode, then builds L-1 extension values on each side of the signal, each through
// two RAM reads and one write, then for each odd offset runs L multiply-accumulate
// steps on one shared MAC pair followed by a drain step and an output step. The
// input is held not ready all the while. Results leave through an output register,
// so a result waiting on the master side does not block the next offset's
// accumulation. Configuration must be written through the APB port only while the
// block is idle; the block itself does not enforce this.
module dwt_q7_single_level import dwtq7_pkg::*; #(
    parameter int MAX_SAMPLES = 64,
    parameter int MAX_TAPS    = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // tap_index[4:0], low_tap[12:5], high_tap[20:13],
                                    // sample[28:21], zeros[31:29]
    input  logic        i_s_tuser,  // operation
    input  logic        i_s_tlast,  // last_sample
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // approx[7:0], detail[15:8]
    output logic        o_m_tlast,  // last_result
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int TW = $clog2(MAX_TAPS);
    localparam int LW = $clog2(MAX_TAPS + 1);
    localparam int OW = $clog2(MAX_SAMPLES + MAX_TAPS + 2);
    localparam int PW = OW + 1;
    localparam int NW = CW + 2;

    // configuration registers
    logic [2:0] r_edge_mode;
    logic [4:0] r_filter_taps;

    // control
    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_n, n_n;
    logic [LW-1:0] r_taps, n_taps;
    logic [2:0]    r_emode, n_emode;
    logic [TW-1:0] r_m, n_m;
    logic [CW:0]   r_p, n_p;
    logic          r_h, n_h;
    logic [OW-1:0] r_o, n_o;
    logic [LW-1:0] r_j, n_j;
    logic          r_out_valid, n_out_valid;
    t_mac_ctl      r_st_ctl, n_st_ctl;

    // payload
    logic signed [DW-1:0] r_low_taps  [MAX_TAPS];
    logic signed [DW-1:0] r_high_taps [MAX_TAPS];
    logic signed [XW-1:0] r_left_ext  [MAX_TAPS];
    logic signed [XW-1:0] r_right_ext [MAX_TAPS];
    logic signed [DW-1:0] r_x0, r_xn1;
    logic signed [XW-1:0] r_lbase, r_rbase;
    logic signed [DW-1:0] r_d1;
    logic signed [XW-1:0] r_st_ext;
    logic                 r_st_sel;
    logic [LW-1:0]        r_st_j;
    logic [DW-1:0]        r_approx, r_detail;
    logic                 r_last;

    // input fields
    logic [4:0]           in_tap_index;
    logic signed [DW-1:0] in_low_tap, in_high_tap, in_sample;
    logic                 s_acc, m_acc, cfg_wr;
    logic                 tap_wr, smp_wr, store_free;

    // datapath helpers
    logic [DW-1:0]        ram_rdata;
    logic [AW-1:0]        ram_raddr;
    logic [15:0]          ft_w;
    logic [LW-1:0]        taps_eff;
    logic [2:0]           emode_eff;
    logic [NW-1:0]        n_w, p_w;
    logic [AW-1:0]        a1, a2;
    logic signed [XW-1:0] d1s, d2s, x0s, xn1s, lv, rv;
    logic signed [PW-1:0] pos;
    logic [OW-1:0]        limit;
    logic                 out_last;
    logic signed [XW-1:0] mac_value;
    logic signed [ACC_W-1:0] acc_lo, acc_hi;

    assign in_tap_index = i_s_tdata[4:0];
    assign in_low_tap   = i_s_tdata[12:5];
    assign in_high_tap  = i_s_tdata[20:13];
    assign in_sample    = i_s_tdata[28:21];

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_acc      = r_out_valid && i_m_tready;
    assign store_free = (r_count < CW'(MAX_SAMPLES));
    assign tap_wr     = s_acc && (i_s_tuser == OP_TAP) && (32'(in_tap_index) < MAX_TAPS);
    assign smp_wr     = s_acc && (i_s_tuser == OP_SAMPLE) && store_free;

    // APB: pready tied high, registers decoded on paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_EDGE_MODE:   prdata = {29'd0, r_edge_mode};
            REG_FILTER_TAPS: prdata = {27'd0, r_filter_taps};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_mode   <= EDGE_ZERO;
            r_filter_taps <= 5'd2;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_EDGE_MODE:   r_edge_mode   <= pwdata[2:0];
                REG_FILTER_TAPS: r_filter_taps <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Effective tap count: clamp to MAX_TAPS, force even, floor at two
    always_comb begin
        ft_w = 16'(r_filter_taps);
        if (ft_w > 16'(MAX_TAPS)) begin
            ft_w = 16'(MAX_TAPS);
        end
        ft_w[0] = 1'b0;
        if (ft_w < 16'd2) begin
            ft_w = 16'd2;
        end
        taps_eff = LW'(ft_w);
    end

    // Effective mode: unused codes act as zero, reflect modes on one sample as constant
    always_comb begin
        emode_eff = r_edge_mode;
        if (r_edge_mode > EDGE_AREFL) begin
            emode_eff = EDGE_ZERO;
        end else if ((r_edge_mode == EDGE_REFL || r_edge_mode == EDGE_AREFL)
                     && r_n < CW'(2)) begin
            emode_eff = EDGE_CONST;
        end
    end

    // Edge read addresses for the current extension step
    assign n_w = NW'(r_n);
    assign p_w = NW'(r_p);

    always_comb begin
        a1 = '0;
        a2 = '0;
        case (r_emode) inside
            EDGE_SYM, EDGE_ASYM: begin
                if (p_w < n_w) begin
                    a1 = AW'(p_w);
                    a2 = AW'(n_w - NW'(1) - p_w);
                end else begin
                    a1 = AW'(NW'(2) * n_w - NW'(1) - p_w);
                    a2 = AW'(p_w - n_w);
                end
            end
            EDGE_REFL: begin
                if (p_w < n_w - NW'(1)) begin
                    a1 = AW'(p_w + NW'(1));
                    a2 = AW'(n_w - NW'(2) - p_w);
                end else begin
                    a1 = AW'(NW'(2) * n_w - NW'(3) - p_w);
                    a2 = AW'(p_w - n_w + NW'(2));
                end
            end
            EDGE_AREFL: begin
                a1 = AW'(p_w);
                a2 = AW'(n_w - NW'(1) - p_w);
            end
            default: ;
        endcase
    end

    // Extension values from the two reads (d1 held, d2 straight off the RAM)
    assign d1s  = XW'(r_d1);
    assign d2s  = XW'($signed(ram_rdata));
    assign x0s  = XW'(r_x0);
    assign xn1s = XW'(r_xn1);

    always_comb begin
        lv = '0;
        rv = '0;
        case (r_emode) inside
            EDGE_CONST: begin
                lv = x0s;
                rv = xn1s;
            end
            EDGE_SYM, EDGE_ASYM: begin
                lv = d1s;
                rv = d2s;
                if (r_emode == EDGE_ASYM && p_w < n_w) begin
                    lv = -d1s;
                    rv = -d2s;
                end
            end
            EDGE_REFL: begin
                lv = d1s;
                rv = d2s;
            end
            EDGE_AREFL: begin
                if (!r_h) begin
                    lv = r_lbase - (d1s - x0s);
                    rv = r_rbase - (d2s - xn1s);
                end else begin
                    lv = r_lbase + (d2s - xn1s);
                    rv = r_rbase + (d1s - x0s);
                end
            end
            default: ;
        endcase
    end

    // Convolution position for the issuing tap
    assign pos      = $signed({1'b0, r_o}) - $signed(PW'(r_j));
    assign limit    = OW'(r_n) + OW'(r_taps) - OW'(1);
    assign out_last = (r_o + OW'(2)) >= limit;

    always_comb begin
        ram_raddr = AW'(pos);
        unique case (r_state)
            ST_EDGE_RD1: ram_raddr = a1;
            ST_EDGE_RD2: ram_raddr = a2;
            default: ;
        endcase
    end

    // Sequencer: next state and control registers
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_n         = r_n;
        n_taps      = r_taps;
        n_emode     = r_emode;
        n_m         = r_m;
        n_p         = r_p;
        n_h         = r_h;
        n_o         = r_o;
        n_j         = r_j;
        n_st_ctl    = '{valid: 1'b0, first: 1'b0};
        n_out_valid = r_out_valid && !m_acc;

        unique case (r_state)
            ST_IDLE: begin
                if (smp_wr) begin
                    n_count = r_count + CW'(1);
                end
                if (s_acc && i_s_tuser == OP_SAMPLE && i_s_tlast) begin
                    n_n     = store_free ? r_count + CW'(1) : r_count;
                    n_count = '0;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_taps  = taps_eff;
                n_emode = emode_eff;
                n_m     = '0;
                n_p     = (emode_eff == EDGE_AREFL) ? (CW+1)'(1) : '0;
                n_h     = 1'b0;
                n_state = ST_EDGE_RD1;
            end
            ST_EDGE_RD1: n_state = ST_EDGE_RD2;
            ST_EDGE_RD2: n_state = ST_EDGE_WR;
            ST_EDGE_WR: begin
                // advance the mirror walk
                case (r_emode) inside
                    EDGE_SYM, EDGE_ASYM: begin
                        n_p = (p_w + NW'(1) == NW'(2) * n_w) ? '0 : r_p + (CW+1)'(1);
                    end
                    EDGE_REFL: begin
                        n_p = (p_w + NW'(1) == NW'(2) * n_w - NW'(2)) ? '0
                            : r_p + (CW+1)'(1);
                    end
                    EDGE_AREFL: begin
                        if (p_w == n_w - NW'(1)) begin
                            n_p = (CW+1)'(1);
                            n_h = !r_h;
                        end else begin
                            n_p = r_p + (CW+1)'(1);
                        end
                    end
                    default: ;
                endcase
                if (LW'(r_m) == r_taps - LW'(2)) begin
                    n_o     = OW'(1);
                    n_j     = '0;
                    n_state = ST_CALC;
                end else begin
                    n_m     = r_m + TW'(1);
                    n_state = ST_EDGE_RD1;
                end
            end
            ST_CALC: begin
                n_st_ctl = '{valid: 1'b1, first: (r_j == '0)};
                if (r_j == r_taps - LW'(1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_j = r_j + LW'(1);
                end
            end
            ST_DRAIN: n_state = ST_FLUSH;
            ST_FLUSH: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    if (out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_o     = r_o + OW'(2);
                        n_j     = '0;
                        n_state = ST_CALC;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_n         <= '0;
            r_taps      <= LW'(2);
            r_emode     <= EDGE_ZERO;
            r_m         <= '0;
            r_p         <= '0;
            r_h         <= 1'b0;
            r_o         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
            r_st_ctl    <= '{valid: 1'b0, first: 1'b0};
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_n         <= n_n;
            r_taps      <= n_taps;
            r_emode     <= n_emode;
            r_m         <= n_m;
            r_p         <= n_p;
            r_h         <= n_h;
            r_o         <= n_o;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
            r_st_ctl    <= n_st_ctl;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (tap_wr) begin
            r_low_taps[TW'(in_tap_index)]  <= in_low_tap;
            r_high_taps[TW'(in_tap_index)] <= in_high_tap;
        end
        if (smp_wr) begin
            r_xn1 <= in_sample;
            if (r_count == '0) begin
                r_x0 <= in_sample;
            end
        end
        if (r_state == ST_START) begin
            r_lbase <= x0s;
            r_rbase <= xn1s;
        end
        if (r_state == ST_EDGE_RD2) begin
            r_d1 <= $signed(ram_rdata);
        end
        if (r_state == ST_EDGE_WR) begin
            r_left_ext[r_m]  <= lv;
            r_right_ext[r_m] <= rv;
            // carry the antireflect base forward at the end of each period
            if (r_emode == EDGE_AREFL && p_w == n_w - NW'(1)) begin
                r_lbase <= lv;
                r_rbase <= rv;
            end
        end
        if (r_state == ST_CALC) begin
            r_st_j <= r_j;
            if (pos[PW-1]) begin
                r_st_sel <= 1'b0;
                r_st_ext <= r_left_ext[TW'(~pos)];
            end else if (pos[OW-1:0] >= OW'(r_n)) begin
                r_st_sel <= 1'b0;
                r_st_ext <= r_right_ext[TW'(pos[OW-1:0] - OW'(r_n))];
            end else begin
                r_st_sel <= 1'b1;
                r_st_ext <= '0;
            end
        end
        if (r_state == ST_FLUSH && (!r_out_valid || i_m_tready)) begin
            r_approx <= acc_lo[Q_SHIFT +: DW];
            r_detail <= acc_hi[Q_SHIFT +: DW];
            r_last   <= out_last;
        end
    end

    dwtq7_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (smp_wr),
        .i_waddr (AW'(r_count)),
        .i_wdata (in_sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign mac_value = r_st_sel ? XW'($signed(ram_rdata)) : r_st_ext;

    dwtq7_mac u_mac (
        .i_clk      (i_clk),
        .i_ctl      (r_st_ctl),
        .i_value    (mac_value),
        .i_low_tap  (r_low_taps[TW'(r_st_j)]),
        .i_high_tap (r_high_taps[TW'(r_st_j)]),
        .o_acc_lo   (acc_lo),
        .o_acc_hi   (acc_hi)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_detail, r_approx};
    assign o_m_tlast  = r_last;

endmodule

[dv/tb.sv]
// Self-checking bench for dwt_q7_single_level: drives tap and sample transactions and
// checks each approximation/detail pair against a bench-side wavelet predictor.
// Depends only on dwtq7_pkg and the RTL of the block.
module tb import dwtq7_pkg::*; ();

    localparam int N_SIG       = 64;
    localparam int N_TAPS      = 20;
    localparam int ITEM_TARGET = 270;
    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE_CYC  = 60;
    localparam int HOLD_CYC    = 800;

    typedef struct {
        logic             op;
        logic [4:0]       idx;
        logic signed [7:0] lo;
        logic signed [7:0] hi;
        logic signed [7:0] smp;
        logic             last;
    } t_item;

    typedef struct {
        logic [7:0] approx;
        logic [7:0] detail;
        logic       last;
    } t_coef;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic        o_m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dwt_q7_single_level i_dut (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .o_s_tready, .i_s_tdata, .i_s_tuser, .i_s_tlast,
        .o_m_tvalid, .i_m_tready, .o_m_tdata, .o_m_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #6 i_clk = ~i_clk;

    // Predictor state: mirrors the block's stores and registers
    int         sig_mem [N_SIG];
    int         lo_taps [N_TAPS];
    int         hi_taps [N_TAPS];
    int         lext [N_TAPS];
    int         rext [N_TAPS];
    int         held_cnt = 0;
    logic [2:0] edge_sel = EDGE_ZERO;
    logic [4:0] taps_reg = 5'd2;

    t_item pend_q[$];
    t_coef coef_q[$];
    int    n_items = 0;
    int    n_errors = 0;
    logic  s_fire = 1'b0;
    logic  hold_req = 1'b0;

    // Fill the extension values beyond both edges of the held signal
    function automatic void build_edges(int n, int cnt, logic [2:0] mode);
        int lb, rb, lv, rv, p, h, kk;
        logic [2:0] md;
        md = mode;
        lb = sig_mem[0];
        rb = sig_mem[n-1];
        if ((md == EDGE_REFL || md == EDGE_AREFL) && n < 2) md = EDGE_CONST;
        for (int m = 0; m < cnt; m++) begin
            lv = 0;
            rv = 0;
            case (md)
                EDGE_CONST: begin
                    lv = sig_mem[0];
                    rv = sig_mem[n-1];
                end
                EDGE_SYM, EDGE_ASYM: begin
                    p = m % (2*n);
                    if (p < n) begin
                        lv = sig_mem[p];
                        rv = sig_mem[n-1-p];
                        if (md == EDGE_ASYM) begin
                            lv = -lv;
                            rv = -rv;
                        end
                    end else begin
                        lv = sig_mem[2*n-1-p];
                        rv = sig_mem[p-n];
                    end
                end
                EDGE_REFL: begin
                    p = m % (2*n-2);
                    if (p < n-1) begin
                        lv = sig_mem[p+1];
                        rv = sig_mem[n-2-p];
                    end else begin
                        lv = sig_mem[2*n-3-p];
                        rv = sig_mem[p-n+2];
                    end
                end
                EDGE_AREFL: begin
                    h  = m / (n-1);
                    kk = m % (n-1) + 1;
                    if (h % 2 == 0) begin
                        lv = lb - (sig_mem[kk] - sig_mem[0]);
                        rv = rb - (sig_mem[n-1-kk] - sig_mem[n-1]);
                    end else begin
                        lv = lb + (sig_mem[n-1-kk] - sig_mem[n-1]);
                        rv = rb + (sig_mem[kk] - sig_mem[0]);
                    end
                    if (kk == n-1) begin
                        lb = lv;
                        rb = rv;
                    end
                end
                default: ;
            endcase
            lext[m] = lv;
            rext[m] = rv;
        end
    endfunction

    // Work out every coefficient pair of one transform and queue it
    task automatic predict_wavelet();
        int taps, n, pos, v, acc_lo, acc_hi;
        logic [31:0] ul, uh;
        t_coef c;
        n = held_cnt;
        taps = (taps_reg > N_TAPS) ? N_TAPS : int'(taps_reg);
        taps = taps & ~1;
        if (taps < 2) taps = 2;
        build_edges(n, taps-1, edge_sel);
        for (int o = 1; o < n + taps - 1; o += 2) begin
            acc_lo = 0;
            acc_hi = 0;
            for (int j = 0; j < taps; j++) begin
                pos = o - j;
                if (pos < 0) v = lext[-pos-1];
                else if (pos >= n) v = rext[pos-n];
                else v = sig_mem[pos];
                acc_lo += lo_taps[j] * v;
                acc_hi += hi_taps[j] * v;
            end
            ul = acc_lo;
            uh = acc_hi;
            c.approx = ul[14:7];
            c.detail = uh[14:7];
            c.last   = (o + 2 >= n + taps - 1);
            coef_q.push_back(c);
        end
        held_cnt = 0;
    endtask

    // Input monitor: advance the predictor on every accepted transaction
    always @(posedge i_clk) begin
        s_fire <= i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            if (i_s_tuser == OP_TAP) begin
                if (i_s_tdata[4:0] < N_TAPS) begin
                    lo_taps[i_s_tdata[4:0]] = int'($signed(i_s_tdata[12:5]));
                    hi_taps[i_s_tdata[4:0]] = int'($signed(i_s_tdata[20:13]));
                end
            end else begin
                if (held_cnt < N_SIG) begin
                    sig_mem[held_cnt] = int'($signed(i_s_tdata[28:21]));
                    held_cnt++;
                end
                if (i_s_tlast) predict_wavelet();
            end
        end
    end

    // Output monitor: compare each accepted pair with the oldest expectation
    always @(posedge i_clk) begin
        t_coef c;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (coef_q.size() == 0) begin
                if (n_errors < 10)
                    $display("unexpected result: approx %0d detail %0d last %0b",
                             $signed(o_m_tdata[7:0]), $signed(o_m_tdata[15:8]), o_m_tlast);
                n_errors++;
            end else begin
                c = coef_q.pop_front();
                if (o_m_tdata[7:0] !== c.approx || o_m_tdata[15:8] !== c.detail
                        || o_m_tlast !== c.last) begin
                    if (n_errors < 10)
                        $display("mismatch: exp approx %0d detail %0d last %0b, got %0d %0d %0b",
                                 $signed(c.approx), $signed(c.detail), c.last,
                                 $signed(o_m_tdata[7:0]), $signed(o_m_tdata[15:8]), o_m_tlast);
                    n_errors++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Driver: hold the current transaction until accepted, then advance after a gap
    int s_gap = 0;
    int s_burst = 0;
    always @(negedge i_clk) begin
        t_item it;
        if (i_rst_n && !(i_s_tvalid && !s_fire)) begin
            if (s_gap > 0) begin
                s_gap--;
                i_s_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                it = pend_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= it.op;
                i_s_tlast  <= it.last;
                i_s_tdata  <= {3'b000, it.smp, it.hi, it.lo, it.idx};
                if (s_burst > 0) begin
                    s_burst--;
                    s_gap = 0;
                end else begin
                    s_gap = pick_gap();
                    if ($urandom_range(0, 19) == 0) s_burst = $urandom_range(10, 40);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    int m_gap = 0;
    int m_hold = 0;
    logic hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            m_hold = HOLD_CYC;
        end
        if (m_hold > 0) begin
            m_hold--;
            i_m_tready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            m_gap = pick_gap();
        end
    end

    // Watchdog: end the run if nothing moves for too long
    int idle_cyc = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    task automatic apb_write(logic reg_sel, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == REG_EDGE_MODE) edge_sel = value[2:0];
        else taps_reg = value[4:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(logic [2:0] mode, logic [4:0] taps);
        apb_write(REG_EDGE_MODE, {29'd0, mode});
        apb_write(REG_FILTER_TAPS, {27'd0, taps});
    endtask

    task automatic push_tap(logic [4:0] idx, logic [7:0] lo, logic [7:0] hi);
        t_item it;
        it.op   = OP_TAP;
        it.idx  = idx;
        it.lo   = lo;
        it.hi   = hi;
        it.smp  = 8'($urandom());  // ignored for a tap write
        it.last = 1'($urandom_range(0, 1));
        pend_q.push_back(it);
        n_items++;
    endtask

    task automatic push_sample(logic [7:0] smp, logic last);
        t_item it;
        it.op   = OP_SAMPLE;
        it.idx  = 5'($urandom());  // tap fields are ignored for a sample
        it.lo   = 8'($urandom());
        it.hi   = 8'($urandom());
        it.smp  = smp;
        it.last = last;
        pend_q.push_back(it);
        n_items++;
    endtask

    task automatic push_signal(int len);
        for (int k = 0; k < len; k++) push_sample(8'($urandom()), k == len - 1);
    endtask

    // Wait for the block to go idle before touching its registers
    task automatic settle_block();
        while (pend_q.size() > 0 || i_s_tvalid || coef_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    initial begin
        int len;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: load every tap pair, extremes first; out-of-range indexes write nothing
        configure(EDGE_ZERO, 5'd2);
        push_tap(5'd0, 8'h80, 8'h7f);
        push_tap(5'd1, 8'h7f, 8'h80);
        for (int t = 2; t < N_TAPS; t++) push_tap(t[4:0], 8'($urandom()), 8'($urandom()));
        push_tap(5'd31, 8'($urandom()), 8'($urandom()));
        push_tap(5'd20, 8'($urandom()), 8'($urandom()));
        // single-sample signal, then extreme samples
        push_sample(8'h80, 1'b1);
        push_sample(8'h7f, 1'b0);
        push_sample(8'h80, 1'b1);
        settle_block();

        // single sample under reflect and antireflect
        configure(EDGE_REFL, 5'd6);
        push_sample(8'h7f, 1'b1);
        settle_block();
        configure(EDGE_AREFL, 5'd31);
        push_sample(8'h81, 1'b1);
        settle_block();

        // store full with the longest filter; hold the receiver off so the block stalls
        configure(EDGE_SYM, 5'd20);
        hold_req = 1'b1;
        push_signal(66);
        push_signal(3);
        settle_block();

        // odd and too-small tap counts, unused modes
        configure(3'd7, 5'd0);
        push_signal(5);
        settle_block();
        configure(3'd6, 5'd21);
        push_signal(4);
        settle_block();

        // Random phases: mostly short signals with occasional tap rewrites
        while (n_items < ITEM_TARGET) begin
            configure(3'($urandom_range(0, 7)),
                      5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(2, 8)));
            for (int s = 0; s < 3; s++) begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        push_tap(5'($urandom()), 8'($urandom()), 8'($urandom()));
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        push_tap(5'($urandom()), 8'($urandom()), 8'($urandom()));
                    push_sample(8'($urandom()), k == len - 1);
                end
            end
            settle_block();
        end

        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
